@@ sv/tick_to_seconds_nanoseconds_unit_assert.svh @@
// ---------------------------------------------------------------------------
// tick to seconds/nanoseconds assertion macros
// implication checks on the clock and synchronous reset of the unit
// ---------------------------------------------------------------------------
`ifndef TICK_TO_SECONDS_NANOSECONDS_UNIT_ASSERT_SVH
`define TICK_TO_SECONDS_NANOSECONDS_UNIT_ASSERT_SVH

// same-cycle implication
`define T2SN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define T2SN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/t2sn_pkg.sv @@
// ---------------------------------------------------------------------------
// t2sn_pkg
// shared widths and constants of the tick to seconds/nanoseconds unit
// ---------------------------------------------------------------------------
package t2sn_pkg;
    localparam int TICK_W   = 64;
    localparam int RATIO_W  = 32;
    localparam int PROD_W   = TICK_W + RATIO_W;
    localparam int NS_W     = 30;
    localparam int OUT_W    = 96;
    localparam logic [RATIO_W-1:0] NS_PER_SEC = 32'd1000000000;

    localparam logic CFG_MULT = 1'b0;
    localparam logic CFG_DIV  = 1'b1;
endpackage

@@ sv/t2sn_div.sv @@
// ---------------------------------------------------------------------------
// t2sn_div
// pipelined restoring divider, one quotient bit per register stage
// ---------------------------------------------------------------------------
module t2sn_div #(
    parameter int QW = t2sn_pkg::PROD_W,
    parameter int DW = t2sn_pkg::RATIO_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem0,       // starting partial remainder, below divisor
    input  logic [QW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic [DW-1:0] o_rem
);
    logic [QW-1:0] r_q   [0:QW-1];
    logic [DW-1:0] r_rem [0:QW-1];
    logic          r_v   [0:QW-1];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [QW-1:0] w_pq;
        logic [DW-1:0] w_prem;
        logic          w_pv;
        logic [DW:0]   w_cur;
        logic [DW:0]   w_diff;
        logic          w_bit;
        logic [QW-1:0] n_q;
        logic [DW-1:0] n_rem;

        if (g == 0) begin : g_first
            assign w_pq   = i_dividend;
            assign w_prem = i_rem0;
            assign w_pv   = i_valid;
        end else begin : g_next
            assign w_pq   = r_q[g-1];
            assign w_prem = r_rem[g-1];
            assign w_pv   = r_v[g-1];
        end

        always_comb begin
            w_cur  = {w_prem, w_pq[QW-1]};
            w_diff = w_cur - {1'b0, i_divisor};
            w_bit  = (w_cur >= {1'b0, i_divisor});
            n_rem  = w_bit ? w_diff[DW-1:0] : w_cur[DW-1:0];
            n_q    = {w_pq[QW-2:0], w_bit};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g]   <= n_q;
                r_rem[g] <= n_rem;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_rem   = r_rem[QW-1];
endmodule

@@ sv/tick_to_seconds_nanoseconds_unit.sv @@
// pipeline: 2 multiply stages, 96 stages dividing by divisor*1e9, 30 stages
//   dividing that remainder by the divisor, 1 output register
// throughput: one transfer per cycle; the whole pipeline holds only while a
//   finished result is stalled at the output
// reset: i_rst_n synchronous active low clears all valid bits and sets both
//   ratio registers to 1
// ---------------------------------------------------------------------------
// tick_to_seconds_nanoseconds_unit
// converts a 64-bit tick count to whole seconds and remaining nanoseconds
// ---------------------------------------------------------------------------
`include "tick_to_seconds_nanoseconds_unit_assert.svh"

module tick_to_seconds_nanoseconds_unit #(
    parameter int RW = t2sn_pkg::RATIO_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config write port: index 0 multiplier, 1 divisor
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [RW-1:0]               i_cfg_data,
    // slave side; tdata: tick_count[63:0]
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [t2sn_pkg::TICK_W-1:0] i_s_axis_tdata,
    // master side; tdata: whole_seconds[63:0], rest_nanoseconds[93:64],
    // seconds_saturated[94], zero pad [95]
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [t2sn_pkg::OUT_W-1:0]  o_m_axis_tdata
);
    localparam int TW = t2sn_pkg::TICK_W;
    localparam int HW = TW / 2;
    localparam int PW = TW + RW;
    localparam int NW = t2sn_pkg::NS_W;
    // divisor scaled by one second
    localparam int SW = RW + NW;

    // ratio registers
    logic [RW-1:0] r_mult, r_div;
    logic [RW-1:0] w_div_eff;
    logic [SW-1:0] r_div_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= RW'(1);
            r_div  <= RW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                t2sn_pkg::CFG_MULT: r_mult <= i_cfg_data;
                t2sn_pkg::CFG_DIV:  r_div  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero divisor behaves as one
    assign w_div_eff = (r_div == '0) ? RW'(1) : r_div;

    // divisor times 1e9, registered from the effective divisor; settles in the cycle
    // after a write, well before any item reaches the first divider stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_sec <= SW'(t2sn_pkg::NS_PER_SEC);
        end else begin
            r_div_sec <= SW'(w_div_eff) * SW'(t2sn_pkg::NS_PER_SEC);
        end
    end

    // global advance: everything moves unless the output is held
    logic w_en;
    assign w_en = !(o_m_axis_tvalid && !i_m_axis_tready);
    assign o_s_axis_tready = w_en;

    // stage 1: two 32x32 partial products
    logic               r_v1;
    logic [HW+RW-1:0]   r_plo, r_phi;
    // stage 2: 96-bit product
    logic               r_v2;
    logic [PW-1:0]      r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_plo  <= i_s_axis_tdata[HW-1:0] * r_mult;
            r_phi  <= i_s_axis_tdata[TW-1:HW] * r_mult;
            r_prod <= {r_phi, {HW{1'b0}}} + {{(PW-HW-RW){1'b0}}, r_plo};
        end
    end

    // seconds = floor(product / (divisor * 1e9)); the remainder of that
    // division, divided by the divisor, is the nanoseconds below one second
    logic          w_v3;
    logic [PW-1:0] w_sec;
    logic [SW-1:0] w_rem_sec;

    t2sn_div #(.QW(PW), .DW(SW)) u_div_sec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_v2),
        .i_rem0     ({SW{1'b0}}),
        .i_dividend (r_prod),
        .i_divisor  (r_div_sec),
        .o_valid    (w_v3),
        .o_quot     (w_sec),
        .o_rem      (w_rem_sec)
    );

    // remainder < divisor * 2^30, so its upper part already sits below the
    // divisor and only 30 quotient bits remain
    logic          w_v4;
    logic [NW-1:0] w_ns;
    logic [RW-1:0] w_ns_rem;

    t2sn_div #(.QW(NW), .DW(RW)) u_div_ns (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_v3),
        .i_rem0     (w_rem_sec[SW-1:NW]),
        .i_dividend (w_rem_sec[NW-1:0]),
        .i_divisor  (w_div_eff),
        .o_valid    (w_v4),
        .o_quot     (w_ns),
        .o_rem      (w_ns_rem)
    );

    // saturated seconds travel beside the nanosecond divider
    logic          w_ovf;
    logic [TW-1:0] r_sec_dly [0:NW-1];
    logic          r_sat_dly [0:NW-1];

    assign w_ovf = (w_sec[PW-1:TW] != '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sec_dly[0] <= w_ovf ? {TW{1'b1}} : w_sec[TW-1:0];
            r_sat_dly[0] <= w_ovf;
            for (int k = 1; k < NW; k++) begin
                r_sec_dly[k] <= r_sec_dly[k-1];
                r_sat_dly[k] <= r_sat_dly[k-1];
            end
        end
    end

    // output register
    logic          r_ov;
    logic [TW-1:0] r_sec;
    logic [NW-1:0] r_ns;
    logic          r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sec <= r_sec_dly[NW-1];
            r_ns  <= w_ns;
            r_sat <= r_sat_dly[NW-1];
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {1'b0, r_sat, r_ns, r_sec};

    // checks
    `T2SN_ASSERT_IMP(a_sat_ones, r_ov && r_sat, r_sec == {TW{1'b1}}, "saturated seconds not all ones")
    `T2SN_ASSERT_IMP(a_ns_range, r_ov, r_ns < NW'(1000000000), "nanoseconds out of range")
    `T2SN_ASSERT_IMP(a_rem_bound, w_v4, w_ns_rem < w_div_eff, "nanosecond remainder not below divisor")
    `T2SN_ASSERT_NXT(a_hold, r_ov && !i_m_axis_tready, r_ov && $stable(r_sec) && $stable(r_ns), "result lost while stalled")
endmodule

@@ tb/tick_to_seconds_nanoseconds_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tick_to_seconds_nanoseconds_unit_tb
// streams tick counts through the unit under several ratio settings and
// compares every result transfer against an in-bench exact-division predictor
// ---------------------------------------------------------------------------
module tick_to_seconds_nanoseconds_unit_tb;

    localparam int PIPE_DEPTH = 129;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic                          saturated;
        logic [t2sn_pkg::NS_W-1:0]     nanos;
        logic [t2sn_pkg::TICK_W-1:0]   seconds;
    } t_timespec;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic                            i_cfg_index = t2sn_pkg::CFG_MULT;
    logic [t2sn_pkg::RATIO_W-1:0]    i_cfg_data = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [t2sn_pkg::TICK_W-1:0]     i_s_axis_tdata = '0;   // tick_count[63:0]
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    // whole_seconds[63:0], rest_nanoseconds[93:64], seconds_saturated[94]
    logic [t2sn_pkg::OUT_W-1:0]      o_m_axis_tdata;

    // ratio registers as the predictor sees them
    logic [t2sn_pkg::RATIO_W-1:0]    ratio_mult = 1;
    logic [t2sn_pkg::RATIO_W-1:0]    ratio_div = 1;

    t_timespec            pending_times[$];
    int                   mismatch_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   hold_off_cycles = 0;
    longint               cycle_count = 0;

    tick_to_seconds_nanoseconds_unit dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tick_to_seconds_nanoseconds_unit_tb failed");
            $finish;
        end
    end

    // exact conversion: 96-bit product, floor divide, split at one second
    function automatic t_timespec convert_ticks(logic [t2sn_pkg::TICK_W-1:0] ticks);
        logic [t2sn_pkg::PROD_W-1:0]  total_ns;
        logic [t2sn_pkg::PROD_W-1:0]  secs_wide;
        logic [t2sn_pkg::RATIO_W-1:0] div_eff;
        t_timespec                    res;
        div_eff = (ratio_div == 0) ? t2sn_pkg::RATIO_W'(1) : ratio_div;
        total_ns = (t2sn_pkg::PROD_W'(ticks) * t2sn_pkg::PROD_W'(ratio_mult))
                   / t2sn_pkg::PROD_W'(div_eff);
        secs_wide = total_ns / t2sn_pkg::PROD_W'(t2sn_pkg::NS_PER_SEC);
        res.nanos = t2sn_pkg::NS_W'(total_ns % t2sn_pkg::PROD_W'(t2sn_pkg::NS_PER_SEC));
        // seconds beyond 64 bits clamp to all ones
        res.saturated = (secs_wide[t2sn_pkg::PROD_W-1:t2sn_pkg::TICK_W] != 0);
        res.seconds = res.saturated ? '1 : secs_wide[t2sn_pkg::TICK_W-1:0];
        return res;
    endfunction

    // receiver ready: random idling, plus a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_timespec want;
        t_timespec got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_timespec'(o_m_axis_tdata[94:0]);
            if (pending_times.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer %h", o_m_axis_tdata);
            end else begin
                want = pending_times.pop_front();
                if (got !== want || o_m_axis_tdata[95] !== 1'b0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: sec %h/%h ns %0d/%0d sat %b/%b",
                                 want.seconds, got.seconds, want.nanos, got.nanos,
                                 want.saturated, got.saturated);
                end
            end
        end
    end

    // one tick-count transfer; expectation queued at the accepting edge;
    // tvalid stays up afterwards so the next item can follow directly
    task automatic send_ticks(logic [t2sn_pkg::TICK_W-1:0] ticks);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= ticks;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_times.push_back(convert_ticks(ticks));
        @(negedge i_clk);
    endtask

    // ratio writes only with the pipeline drained
    task automatic write_ratio(logic idx, logic [t2sn_pkg::RATIO_W-1:0] val);
        i_s_axis_tvalid <= 1'b0;
        wait (pending_times.size() == 0);
        repeat (PIPE_DEPTH + 5) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == t2sn_pkg::CFG_MULT) ratio_mult = val;
        else ratio_div = val;
    endtask

    function automatic logic [t2sn_pkg::TICK_W-1:0] rand_ticks();
        case ($urandom_range(4))
            0: return t2sn_pkg::TICK_W'($urandom_range(2000));
            1: return '1 - t2sn_pkg::TICK_W'($urandom_range(50));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [t2sn_pkg::RATIO_W-1:0] rand_ratio();
        case ($urandom_range(3))
            0: return t2sn_pkg::RATIO_W'($urandom_range(1, 16));
            1: return '1 - t2sn_pkg::RATIO_W'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    // edge values under reset ratio, max multiplier and max divisor, then zero multiplier and zero divisor
    task automatic test_extremes();
        logic [t2sn_pkg::TICK_W-1:0] edge_ticks[6];
        edge_ticks = '{64'd0, 64'd1, 64'd999999999, 64'd1000000000, '1,
                       64'h5555_AAAA_5555_AAAA};
        foreach (edge_ticks[k]) send_ticks(edge_ticks[k]);
        write_ratio(t2sn_pkg::CFG_MULT, '1);        // seconds overflow case
        foreach (edge_ticks[k]) send_ticks(edge_ticks[k]);
        write_ratio(t2sn_pkg::CFG_DIV, '1);
        foreach (edge_ticks[k]) send_ticks(edge_ticks[k]);
        write_ratio(t2sn_pkg::CFG_MULT, '0);        // zero multiplier gives zero time
        send_ticks('1);
        send_ticks(64'h1234_5678_9ABC_DEF0);
        write_ratio(t2sn_pkg::CFG_DIV, '0);         // zero divisor acts as one
        write_ratio(t2sn_pkg::CFG_MULT, 32'd3);
        send_ticks('1);
        send_ticks(64'd333333333);
    endtask

    task automatic test_random_ratios(int items, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int k = 0; k < items; k++) begin
            if (k % 40 == 0) begin
                write_ratio(t2sn_pkg::CFG_MULT, rand_ratio());
                write_ratio(t2sn_pkg::CFG_DIV, rand_ratio());
            end
            send_ticks(rand_ticks());
        end
    endtask

    // receiver stalls long enough for the pipeline to fill and back up
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 3 * PIPE_DEPTH;
        for (int k = 0; k < 200; k++) send_ticks({$urandom, $urandom});
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_random_ratios(170, 12, 62);
        test_random_ratios(170, 62, 12);
        test_random_ratios(140, 0, 0);
        test_backpressure();
        i_s_axis_tvalid <= 1'b0;
        wait (pending_times.size() == 0);
        repeat (PIPE_DEPTH + 10) @(negedge i_clk);
        if (mismatch_count == 0 && pending_times.size() == 0)
            $display("tick_to_seconds_nanoseconds_unit_tb passed");
        else
            $display("tick_to_seconds_nanoseconds_unit_tb failed");
        $finish;
    end
endmodule
